/* hdl/ttip_pkg.sv */
// Shared types, character codes and the digit decoder for the text-to-integer parser.
// Used by every module of the parser; depends on nothing else.
`timescale 1ns / 1ps

package ttip_pkg;

   localparam int RADIX_WIDTH = 6;

   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_WIDTH-1:0] RADIX_AUTO  = 6'd0;
   localparam logic [RADIX_WIDTH-1:0] BASE_OCT    = 6'd8;
   localparam logic [RADIX_WIDTH-1:0] BASE_DEC    = 6'd10;
   localparam logic [RADIX_WIDTH-1:0] BASE_HEX    = 6'd16;
   localparam logic [RADIX_WIDTH-1:0] NOT_DIGIT   = 6'd63;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;
   localparam logic [7:0] CHAR_LO_X  = 8'h78;
   localparam logic [7:0] UP_LETTER_BIAS = CHAR_UP_A - 8'd10;
   localparam logic [7:0] LO_LETTER_BIAS = CHAR_LO_A - 8'd10;

   typedef struct packed {
      logic [7:0] ch;
      logic       first;
   } char_item_type;

   function automatic logic [RADIX_WIDTH-1:0] digit_of(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = c - CHAR_ZERO;
      end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
         d = c - UP_LETTER_BIAS;
      end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
         d = c - LO_LETTER_BIAS;
      end else begin
         d = {2'b00, NOT_DIGIT};
      end
      return d[RADIX_WIDTH-1:0];
   endfunction

endpackage

/* hdl/ttip_in_reg.sv */
// Input register of the parser: holds one character transfer until the core takes it.
// Depends on ttip_pkg for the character item type.
`timescale 1ns / 1ps

module ttip_in_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ttip_pkg::char_item_type req_item,
   output logic                   item_valid,
   input  logic                   item_take,
   output ttip_pkg::char_item_type item
);

   logic                    valid_ff;
   logic                    valid_in;
   ttip_pkg::char_item_type item_ff;

   assign req_ready  = !valid_ff || item_take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

/* hdl/ttip_digit_mac.sv */
// Multiply-add of one digit into the accumulator with the signed range check.
// Depends on ttip_pkg for the radix width.
`timescale 1ns / 1ps

module ttip_digit_mac #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic [VALUE_WIDTH-1:0]           acc,
   input  logic [ttip_pkg::RADIX_WIDTH-1:0] base,
   input  logic [ttip_pkg::RADIX_WIDTH-1:0] digit,
   input  logic                             negative,
   output logic [VALUE_WIDTH-1:0]           sum,
   output logic                             over
);

   localparam int WIDE = VALUE_WIDTH + ttip_pkg::RADIX_WIDTH + 1;

   logic [WIDE-1:0] product;
   logic [WIDE-1:0] wide_sum;
   logic [WIDE-1:0] limit;

   always_comb begin
      product  = {{(WIDE-VALUE_WIDTH){1'b0}}, acc} *
                 {{(WIDE-ttip_pkg::RADIX_WIDTH){1'b0}}, base};
      wide_sum = product + {{(WIDE-ttip_pkg::RADIX_WIDTH){1'b0}}, digit};
      limit    = {{(WIDE-VALUE_WIDTH){1'b0}}, 1'b1, {(VALUE_WIDTH-1){1'b0}}};
      if (!negative) begin
         limit = limit - {{(WIDE-1){1'b0}}, 1'b1};
      end
      over = wide_sum > limit;
      sum  = wide_sum[VALUE_WIDTH-1:0];
   end

endmodule

/* hdl/ttip_parse_core.sv */
// Parse state, radix register and result register of the parser.
// Depends on ttip_pkg and on ttip_digit_mac for the accumulate step.
`timescale 1ns / 1ps

module ttip_parse_core #(
   parameter int VALUE_WIDTH  = 32,
   parameter int OFFSET_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [ttip_pkg::RADIX_WIDTH-1:0] csr_wr_data,
   input  logic                             item_valid,
   output logic                             item_take,
   input  ttip_pkg::char_item_type          item,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [VALUE_WIDTH-1:0]    rsp_value,
   output logic                             rsp_digits_seen,
   output logic [OFFSET_WIDTH-1:0]          rsp_end_offset,
   output logic                             rsp_overflow
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SPACE,
      PH_SIGNED,
      PH_ZERO,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   localparam int RW = ttip_pkg::RADIX_WIDTH;

   phase_type               phase_ff, phase_in;
   logic                    negative_ff, negative_in;
   logic [VALUE_WIDTH-1:0]  acc_ff, acc_in;
   logic                    ovf_ff, ovf_in;
   logic                    any_ff, any_in;
   logic [OFFSET_WIDTH-1:0] pos_ff, pos_in;
   logic [RW-1:0]           base_ff, base_in;
   logic [RW-1:0]           radix_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]  value_ff, value_in;
   logic                    digits_ff;
   logic [OFFSET_WIDTH-1:0] offset_ff, offset_in;
   logic                    overflow_ff;

   logic                    active;
   logic                    at_digits;
   phase_type               pre_phase;
   logic                    pre_neg;
   logic                    pre_any;
   logic [RW-1:0]           pre_base;
   logic [VALUE_WIDTH-1:0]  start_acc;
   logic                    start_ovf;
   logic [OFFSET_WIDTH-1:0] start_pos;
   logic [RW-1:0]           digit;
   logic [VALUE_WIDTH-1:0]  mac_sum;
   logic                    mac_over;
   logic                    emit;
   logic                    advance;

   assign item_take = !rsp_valid_ff || rsp_ready;
   assign advance   = item_valid && item_take;
   assign digit     = ttip_pkg::digit_of(item.ch);

   always_comb begin
      logic go_on;
      logic auto_or_hex;
      go_on       = 1'b1;
      auto_or_hex = (radix_ff == ttip_pkg::RADIX_AUTO) || (radix_ff == ttip_pkg::BASE_HEX);
      active      = item.first || !(phase_ff == PH_IDLE || phase_ff == PH_DONE);
      if (item.first) begin
         pre_phase = PH_SPACE;
         pre_neg   = 1'b0;
         pre_any   = 1'b0;
         pre_base  = '0;
         start_acc = '0;
         start_ovf = 1'b0;
         start_pos = '0;
      end else begin
         pre_phase = phase_ff;
         pre_neg   = negative_ff;
         pre_any   = any_ff;
         pre_base  = base_ff;
         start_acc = acc_ff;
         start_ovf = ovf_ff;
         start_pos = pos_ff;
      end
      if (pre_phase == PH_SPACE) begin
         if (item.ch == ttip_pkg::CHAR_SPACE) begin
            go_on = 1'b0;
         end else if (item.ch == ttip_pkg::CHAR_MINUS) begin
            pre_neg   = 1'b1;
            pre_phase = PH_SIGNED;
            go_on     = 1'b0;
         end else if (item.ch == ttip_pkg::CHAR_PLUS) begin
            pre_phase = PH_SIGNED;
            go_on     = 1'b0;
         end else begin
            pre_phase = PH_SIGNED;
         end
      end
      if (go_on && pre_phase == PH_SIGNED) begin
         if (auto_or_hex && item.ch == ttip_pkg::CHAR_ZERO) begin
            pre_phase = PH_ZERO;
            go_on     = 1'b0;
         end else begin
            pre_base  = (radix_ff == ttip_pkg::RADIX_AUTO) ? ttip_pkg::BASE_DEC : radix_ff;
            pre_phase = PH_DIGITS;
         end
      end
      if (go_on && pre_phase == PH_ZERO) begin
         if (item.ch == ttip_pkg::CHAR_LO_X || item.ch == ttip_pkg::CHAR_UP_X) begin
            pre_base  = ttip_pkg::BASE_HEX;
            pre_phase = PH_DIGITS;
            go_on     = 1'b0;
         end else begin
            pre_base  = (radix_ff == ttip_pkg::RADIX_AUTO) ? ttip_pkg::BASE_OCT : radix_ff;
            pre_any   = 1'b1;
            pre_phase = PH_DIGITS;
         end
      end
      at_digits = go_on && pre_phase == PH_DIGITS;
   end

   ttip_digit_mac #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_mac (
      .acc      (start_acc),
      .base     (pre_base),
      .digit    (digit),
      .negative (pre_neg),
      .sum      (mac_sum),
      .over     (mac_over)
   );

   always_comb begin
      phase_in    = pre_phase;
      negative_in = pre_neg;
      acc_in      = start_acc;
      ovf_in      = start_ovf;
      any_in      = pre_any;
      base_in     = pre_base;
      pos_in      = (start_pos == '1) ? start_pos : start_pos + 1'b1;
      emit        = 1'b0;
      if (at_digits) begin
         if (digit < pre_base) begin
            any_in = 1'b1;
            if (!start_ovf) begin
               if (mac_over) begin
                  ovf_in = 1'b1;
               end else begin
                  acc_in = mac_sum;
               end
            end
         end else begin
            emit     = 1'b1;
            phase_in = PH_DONE;
         end
      end
      if (ovf_in) begin
         value_in = {!negative_in, {(VALUE_WIDTH-1){negative_in}}} ^ {VALUE_WIDTH{1'b1}};
      end else if (negative_in) begin
         value_in = '0 - acc_in;
      end else begin
         value_in = acc_in;
      end
      offset_in    = any_in ? start_pos : '0;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = active && emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
         radix_ff     <= ttip_pkg::RADIX_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            radix_ff <= csr_wr_data;
         end
         if (advance && active) begin
            phase_ff <= phase_in;
         end
      end
      if (advance && active) begin
         negative_ff <= negative_in;
         acc_ff      <= acc_in;
         ovf_ff      <= ovf_in;
         any_ff      <= any_in;
         pos_ff      <= pos_in;
         base_ff     <= base_in;
      end
      if (advance && active && emit) begin
         value_ff    <= value_in;
         digits_ff   <= any_in;
         offset_ff   <= offset_in;
         overflow_ff <= ovf_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = value_ff;
   assign rsp_digits_seen = digits_ff;
   assign rsp_end_offset  = offset_ff;
   assign rsp_overflow    = overflow_ff;

endmodule

/* hdl/text_to_integer_parser.sv */
// Top level of the text-to-integer parser: input register followed by the parse core.
// Depends on ttip_pkg, ttip_in_reg, ttip_parse_core and ttip_digit_mac.
//
// The parser takes one character per cycle and keeps that rate indefinitely while
// rsp_ready stays high; a character is registered in the input register, and the core
// registers the result on the character ending the number. The cycle time is set by the
// single multiply-add and range compare of the accumulator. Spaces are skipped, a sign
// and, for radix 0 or 16, a 0x prefix are taken, and the first character that is not
// a digit of the base, NUL included, produces one result. The user must write the radix
// register via csr_wr_en/csr_wr_data only while no string is in progress (not enforced).
`timescale 1ns / 1ps

module text_to_integer_parser #(
   parameter int VALUE_WIDTH  = 32,
   parameter int OFFSET_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [ttip_pkg::RADIX_WIDTH-1:0] csr_wr_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_ch,
   input  logic                             req_first,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [VALUE_WIDTH-1:0]    rsp_value,
   output logic                             rsp_digits_seen,
   output logic [OFFSET_WIDTH-1:0]          rsp_end_offset,
   output logic                             rsp_overflow
);

   ttip_pkg::char_item_type req_item;
   ttip_pkg::char_item_type item;
   logic                    item_valid;
   logic                    item_take;

   assign req_item.ch    = req_ch;
   assign req_item.first = req_first;

   ttip_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item)
   );

   ttip_parse_core #(
      .VALUE_WIDTH  (VALUE_WIDTH),
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .item_valid      (item_valid),
      .item_take       (item_take),
      .item            (item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value       (rsp_value),
      .rsp_digits_seen (rsp_digits_seen),
      .rsp_end_offset  (rsp_end_offset),
      .rsp_overflow    (rsp_overflow)
   );

endmodule

/* hdl/ttip_checker.sv */
// Port-level checks for the text-to-integer parser, bound to its top level.
// Depends only on the top-level ports of text_to_integer_parser.
`timescale 1ns / 1ps

module ttip_checker #(
   parameter int VALUE_WIDTH  = 32,
   parameter int OFFSET_WIDTH = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [VALUE_WIDTH-1:0] rsp_value,
   input logic                          rsp_digits_seen,
   input logic [OFFSET_WIDTH-1:0]       rsp_end_offset,
   input logic                          rsp_overflow
);

   localparam logic [VALUE_WIDTH-1:0] MOST_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic [VALUE_WIDTH-1:0] MOST_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

   // A stalled result transfer keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) &&
         $stable(rsp_end_offset) && $stable(rsp_overflow) && $stable(rsp_digits_seen))
      else $error("stalled result changed");

   // The input side only stalls when a result is waiting and not taken.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without result back-pressure");

   // A string without digits reports zero everywhere.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_digits_seen |->
         rsp_value == '0 && rsp_end_offset == '0 && !rsp_overflow)
      else $error("no-digit result with nonzero fields");

   // An overflowing number saturates and always ends after at least one character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         rsp_digits_seen && rsp_end_offset != '0 &&
         (rsp_value == MOST_NEG || rsp_value == MOST_POS))
      else $error("overflow result not saturated");

endmodule

bind text_to_integer_parser ttip_checker #(
   .VALUE_WIDTH  (VALUE_WIDTH),
   .OFFSET_WIDTH (OFFSET_WIDTH)
) u_ttip_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_value       (rsp_value),
   .rsp_digits_seen (rsp_digits_seen),
   .rsp_end_offset  (rsp_end_offset),
   .rsp_overflow    (rsp_overflow)
);
